// File: rtl/mft_pkg.sv
// Shared types and constants for the motor feedback multiturn tracker.
package mft_pkg;

  // Default width of the turn counter
  localparam int TURN_BITS_DEF = 32;

  // Port widths
  localparam int IN_W       = 48;
  localparam int OUT_W      = 176;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Arithmetic constants
  localparam logic [19:0] LPF_COEF    = 20'd3873;
  localparam logic [19:0] RADPS_Q20   = 20'd109805;
  localparam logic [20:0] SPEED_LIMIT = 21'd878500;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIR,
    CFG_ZERO,
    CFG_INV,
    CFG_TGAIN
  } cfg_idx_t;

  // Operand selection for the shared multiplier
  typedef enum logic [1:0] {
    MUL_FILT,
    MUL_SPD1,
    MUL_SPD2,
    MUL_TORQ
  } mul_sel_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILT,
    ST_SPD1,
    ST_SPD2,
    ST_TORQ,
    ST_DONE
  } state_t;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic     take;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     filt_take;
    logic     speed_take;
    logic     out_load;
  } mft_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic is_cal;
    logic out_busy;
  } mft_sts_t;

endpackage

// File: rtl/mft_ctrl.sv
// Sequencer for the motor feedback multiturn tracker.
module mft_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  mft_pkg::mft_sts_t  sts,
  output mft_pkg::mft_cmd_t  cmd
);
  import mft_pkg::*;

  state_t state;
  state_t state_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Step through the multiplier passes
  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.mul_sel    = MUL_FILT;
    s_tready       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.take = 1'b1;
          if (!sts.is_cal) begin
            state_next = ST_FILT;
          end
        end
      end
      ST_FILT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_FILT;
        state_next  = ST_SPD1;
      end
      ST_SPD1: begin
        cmd.filt_take = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_SPD1;
        state_next    = ST_SPD2;
      end
      ST_SPD2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SPD2;
        state_next  = ST_TORQ;
      end
      ST_TORQ: begin
        cmd.speed_take = 1'b1;
        cmd.mul_en     = 1'b1;
        cmd.mul_sel    = MUL_TORQ;
        state_next     = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/mft_dpath.sv
// Datapath for the motor feedback multiturn tracker: registers, multiplier, output word.
module mft_dpath #(
  parameter int TURN_BITS = mft_pkg::TURN_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  mft_pkg::mft_cmd_t               cmd,
  output mft_pkg::mft_sts_t               sts,
  input  logic [mft_pkg::IN_W-1:0]        s_tdata,
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mft_pkg::OUT_W-1:0]       m_tdata,
  input  logic                            wr_en,
  input  logic [mft_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [mft_pkg::CFG_DATA_W-1:0]  wr_data
);
  import mft_pkg::*;

  // Configuration registers
  logic        dir;
  logic [12:0] zero;
  logic [16:0] inv;
  logic [19:0] tgain;

  // Tracker state
  logic                        seen_first;
  logic signed [15:0]          last_rpm;
  logic [12:0]                 prev_angle;
  logic signed [TURN_BITS-1:0] turn_count;
  logic [12:0]                 start_offset;
  logic signed [20:0]          held_speed;

  // Word held for the current item
  logic signed [15:0] v_q;
  logic [12:0]        ang_q;
  logic signed [15:0] cur_q;
  logic signed [15:0] filt_q;

  // Multiplier
  logic [31:0] mul_a;
  logic [19:0] mul_b;
  logic        mul_neg;
  logic [51:0] prod;
  logic        prod_neg;

  // Input decode
  logic [12:0]        angle_in;
  logic signed [15:0] speed_in;
  logic signed [15:0] current_in;
  logic [12:0]        ang_adj;
  logic signed [15:0] v_adj;

  // Operand magnitudes
  logic signed [16:0] diff;
  logic [16:0]        diff_abs;
  logic [16:0]        v_abs;
  logic signed [18:0] amps;
  logic [18:0]        amps_abs;

  // Result arithmetic
  logic signed [33:0] filt_prod;
  logic signed [33:0] filt_num;
  logic signed [33:0] filt_adj;
  logic [48:0]        spd_sum;
  logic [20:0]        spd_mag;
  logic [20:0]        spd_sat;
  logic signed [20:0] spd_val;
  logic [38:0]        tq_sum;
  logic [22:0]        tq_mag;
  logic signed [22:0] tq_val;
  logic signed [14:0] adiff;
  logic signed [TURN_BITS-1:0] tc_next;
  logic signed [14:0] wrap_raw;
  logic signed [14:0] wrap_fix;
  logic signed [13:0] wrap_val;
  logic [13:0]        wrap_abs;
  logic [18:0]        deg_sum;
  logic [16:0]        deg_mag;
  logic signed [16:0] deg_val;
  logic signed [31:0] turns32;
  logic [31:0]        total;

  // Output registers
  logic signed [15:0] o_filt;
  logic signed [20:0] o_speed;
  logic signed [18:0] o_amps;
  logic signed [22:0] o_torque;
  logic signed [13:0] o_wrap;
  logic signed [16:0] o_deg;
  logic [31:0]        o_total;
  logic signed [31:0] o_turns;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dir   <= 1'b0;
      zero  <= '0;
      inv   <= '0;
      tgain <= '0;
    end else if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        CFG_DIR:   dir   <= wr_data[0];
        CFG_ZERO:  zero  <= wr_data[12:0];
        CFG_INV:   inv   <= wr_data[16:0];
        CFG_TGAIN: tgain <= wr_data[19:0];
        default:   dir   <= dir;
      endcase
    end
  end

  // Unpack the input word and apply direction
  always_comb begin
    angle_in   = s_tdata[12:0];
    speed_in   = $signed(s_tdata[28:13]);
    current_in = $signed(s_tdata[44:29]);
    ang_adj    = dir ? ~angle_in : angle_in;
    if (!dir) begin
      v_adj = speed_in;
    end else if (speed_in == 16'sh8000) begin
      v_adj = 16'sh7fff;
    end else begin
      v_adj = -speed_in;
    end
  end

  assign sts.is_cal   = s_tuser;
  assign sts.out_busy = m_tvalid & ~m_tready;

  // Magnitudes and signs for the multiplier passes
  always_comb begin
    diff     = 17'(v_q) - 17'(last_rpm);
    diff_abs = diff[16] ? 17'(-diff) : 17'(diff);
    v_abs    = v_q[15] ? 17'(-17'(v_q)) : 17'(v_q);
    amps     = (19'(cur_q) <<< 2) + 19'(cur_q);
    amps_abs = amps[18] ? 19'(-amps) : 19'(amps);
  end

  // Select multiplier operands
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_FILT: begin
        mul_a   = 32'(diff_abs);
        mul_b   = LPF_COEF;
        mul_neg = diff[16];
      end
      MUL_SPD1: begin
        mul_a   = 32'(v_abs);
        mul_b   = 20'(inv);
        mul_neg = v_q[15];
      end
      MUL_SPD2: begin
        mul_a   = prod[31:0];
        mul_b   = RADPS_Q20;
        mul_neg = v_q[15];
      end
      MUL_TORQ: begin
        mul_a   = 32'(amps_abs);
        mul_b   = tgain;
        mul_neg = amps[18];
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
      end
    endcase
  end

  // Shared multiplier with registered product
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod     <= 52'(mul_a) * 52'(mul_b);
      prod_neg <= mul_neg;
    end
  end

  // Filter: last*65536 + 3873*(v - last), truncated toward zero
  always_comb begin
    filt_prod = prod_neg ? -$signed({2'b00, prod[31:0]}) : $signed({2'b00, prod[31:0]});
    filt_num  = $signed({{2{last_rpm[15]}}, last_rpm, 16'h0000}) + filt_prod;
    filt_adj  = filt_num[33] ? filt_num + 34'sd65535 : filt_num;
  end

  // Output speed: round, saturate, restore sign
  always_comb begin
    spd_sum = {1'b0, prod[47:0]} + 49'h0000_0800_0000;
    spd_mag = spd_sum[48:28];
    spd_sat = (spd_mag > SPEED_LIMIT) ? SPEED_LIMIT : spd_mag;
    spd_val = prod_neg ? -$signed(spd_sat) : $signed(spd_sat);
  end

  // Torque: round and restore sign
  always_comb begin
    tq_sum = {1'b0, prod[37:0]} + 39'h00_0000_8000;
    tq_mag = tq_sum[38:16];
    tq_val = prod_neg ? -$signed(tq_mag) : $signed(tq_mag);
  end

  // Turn count, wrapped angle, degrees and total angle
  always_comb begin
    adiff = $signed({2'b00, ang_q}) - $signed({2'b00, prev_angle});
    if (adiff > 15'sd4096) begin
      tc_next = turn_count - TURN_BITS'(1);
    end else if (adiff < -15'sd4096) begin
      tc_next = turn_count + TURN_BITS'(1);
    end else begin
      tc_next = turn_count;
    end
    wrap_raw = $signed({2'b00, ang_q}) - $signed({2'b00, zero});
    if (wrap_raw > 15'sd4096) begin
      wrap_fix = wrap_raw - 15'sd8192;
    end else if (wrap_raw < -15'sd4095) begin
      wrap_fix = wrap_raw + 15'sd8192;
    end else begin
      wrap_fix = wrap_raw;
    end
    wrap_val = wrap_fix[13:0];
    wrap_abs = wrap_val[13] ? 14'(-wrap_val) : 14'(wrap_val);
    deg_sum  = 19'(wrap_abs) * 19'd45 + 19'd2;
    deg_mag  = deg_sum[18:2];
    deg_val  = wrap_val[13] ? -$signed(deg_mag) : $signed(deg_mag);
    turns32  = 32'(tc_next);
    total    = {turns32[18:0], 13'h0000} + 32'(ang_q) - 32'(start_offset);
  end

  // Update tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_first   <= 1'b0;
      last_rpm     <= '0;
      prev_angle   <= '0;
      turn_count   <= '0;
      start_offset <= '0;
      held_speed   <= '0;
    end else begin
      if (cmd.take) begin
        if (s_tuser) begin
          start_offset <= angle_in;
          prev_angle   <= angle_in;
        end else if (!seen_first) begin
          seen_first <= 1'b1;
          last_rpm   <= v_adj;
        end
      end
      if (cmd.speed_take && (inv != '0)) begin
        held_speed <= spd_val;
      end
      if (cmd.out_load) begin
        turn_count <= tc_next;
        prev_angle <= ang_q;
        last_rpm   <= filt_q;
      end
    end
  end

  // Capture the item and intermediate results
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      v_q   <= v_adj;
      ang_q <= ang_adj;
      cur_q <= current_in;
    end
    if (cmd.filt_take) begin
      filt_q <= filt_adj[31:16];
    end
  end

  // Load the output word
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_filt   <= filt_q;
      o_speed  <= held_speed;
      o_amps   <= amps;
      o_torque <= tq_val;
      o_wrap   <= wrap_val;
      o_deg    <= deg_val;
      o_total  <= total;
      o_turns  <= turns32;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {2'b00, o_turns, o_total, o_deg, o_wrap, o_torque, o_amps, o_speed, o_filt};

endmodule

// File: rtl/motor_feedback_multiturn_tracker.sv
// Top level of the motor feedback multiturn tracker.
// Input channel s_*: one word per feedback frame or calibrate request. tuser = 1
// calibrates: the raw angle becomes the start offset and the last angle, and no
// result word follows. tuser = 0 is a feedback frame and gives one result word.
// Output channel m_*: filtered rpm, output shaft speed, current, torque, wrapped
// angle, angle in degrees, total angle and turn count.
// Configuration: wr_en with wr_index selects direction, zero offset, inverse
// ratio or torque gain; write only while no frame is in flight.
// Sequence: a frame taken in ST_IDLE runs ST_FILT, ST_SPD1, ST_SPD2, ST_TORQ and
// ST_DONE, the first four being the passes through the single shared 32x20
// multiplier (filter, two speed products, torque); ST_DONE loads the result.
// A new frame or calibrate word is taken only in ST_IDLE; calibrate stays there.
// The result sits in an output register, so the next frame is taken while it
// waits; if m_tready stays low, the following frame waits in its last step and
// s_tready stays low after it until the output register frees.
// Reset (rst, synchronous) clears registers, turn count, filter and offsets.
module motor_feedback_multiturn_tracker #(
  parameter int TURN_BITS = mft_pkg::TURN_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // angle_raw[12:0], speed_raw[28:13], current_raw[44:29], zero fill
  input  logic [mft_pkg::IN_W-1:0]        s_tdata,
  // action
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // filtered_rpm[15:0], output_speed[36:16], current_amps[55:37], torque[78:56],
  // wrapped_angle[92:79], angle_degrees[109:93], multiturn_angle[141:110],
  // turns[173:142], zero fill
  output logic [mft_pkg::OUT_W-1:0]       m_tdata,
  input  logic                            wr_en,
  input  logic [mft_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [mft_pkg::CFG_DATA_W-1:0]  wr_data
);
  import mft_pkg::*;

  mft_cmd_t cmd;
  mft_sts_t sts;

  mft_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mft_dpath #(
    .TURN_BITS (TURN_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

endmodule
